// ===== design/cprh_pkg.sv =====
// Shared types and constants of the Collatz parity-residue histogram.
// Field widths, status and command codes, and the structs passed between modules.
// No dependencies; every other design file imports this package.
package cprh_pkg;

    localparam int VAL_W     = 64;
    localparam int MOD_W     = 7;
    localparam int IDX_W     = 6;
    localparam int CNT_OUT_W = 12;
    localparam int CELL_W    = 40;
    localparam int SUM_W     = 48;
    localparam int STAT_W    = 3;

    // Largest odd value whose 3x+1 still fits in 64 bits is at most this.
    localparam logic [VAL_W-1:0]     TRIPLE_MAX  = 64'h5555_5555_5555_5554;
    localparam logic [CELL_W-1:0]    CELL_MAX    = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX     = '1;
    localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = '1;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] code;
    } walk_stat_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] halvings;
        logic [CNT_OUT_W-1:0] triplings;
        logic [CELL_W-1:0]    cell_count;
        logic [CNT_OUT_W-1:0] peak_halvings_out;
        logic [CNT_OUT_W-1:0] peak_triplings_out;
        logic [SUM_W-1:0]     steps_total;
        logic [CELL_W-1:0]    trajectories;
    } result_t;

endpackage

// ===== design/cprh_if.sv =====
// Handshake channels of the Collatz parity-residue histogram: request, result, setup.
// Each carries valid, ready and its payload. Depends on cprh_pkg.
interface cprh_req_if
    import cprh_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [VAL_W-1:0] start_value;
    logic [IDX_W-1:0] read_row;
    logic [IDX_W-1:0] read_col;

    modport source (output valid, cmd, start_value, read_row, read_col, input ready);
    modport sink   (input valid, cmd, start_value, read_row, read_col, output ready);
endinterface

interface cprh_res_if
    import cprh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] halvings;
    logic [CNT_OUT_W-1:0] triplings;
    logic [CELL_W-1:0]    cell_count;
    logic [CNT_OUT_W-1:0] peak_halvings_out;
    logic [CNT_OUT_W-1:0] peak_triplings_out;
    logic [SUM_W-1:0]     steps_total;
    logic [CELL_W-1:0]    trajectories;

    modport source (output valid, status, halvings, triplings, cell_count,
                    peak_halvings_out, peak_triplings_out, steps_total, trajectories,
                    input ready);
    modport sink   (input valid, status, halvings, triplings, cell_count,
                    peak_halvings_out, peak_triplings_out, steps_total, trajectories,
                    output ready);
endinterface

interface cprh_cfg_if
    import cprh_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] modulus;

    modport source (output valid, modulus, input ready);
    modport sink   (input valid, modulus, output ready);
endinterface

// ===== design/collatz_parity_residue_histogram.sv =====
// Collatz parity-residue histogram, top level. Depends on cprh_pkg, the channel
// interfaces in cprh_if.sv and the trajectory walker cprh_walker.
//
// After reset the block sweeps the histogram memory to zero, one cell per cycle,
// over all GRID_SIDE*GRID_SIDE cells (4096 with the default), and takes no request
// item meanwhile; setup writes are taken at any time. An accumulate item then passes
// through S_WALK, S_READ, S_UPDATE and S_FINISH: the walker does one 3x+1 or halving
// step per cycle in its single 64-bit unit until it sees the end, and the histogram
// cell is then read, incremented and written back through the one memory port. A walk
// stopped by overflow or the step limit goes from S_WALK straight to S_FINISH.
// A read item passes through S_READ, S_UPDATE and S_FINISH; a zero start or an out of
// range read goes straight to S_FINISH. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
module collatz_parity_residue_histogram
    import cprh_pkg::*;
#(
    parameter int GRID_SIDE  = 64,
    parameter int STEP_LIMIT = 4095
)
(
    input  logic              clk,
    input  logic              rst_n,
    cprh_req_if.sink          request,
    cprh_res_if.source        result,
    cprh_cfg_if.sink          setup
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(STEP_LIMIT + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [MOD_W-1:0]     modulus_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 is_read_reg, is_read_next;
    logic [STAT_W-1:0]    pend_status_reg, pend_status_next;
    logic [CNT_OUT_W-1:0] pend_h_reg, pend_h_next;
    logic [CNT_OUT_W-1:0] pend_t_reg, pend_t_next;
    logic [CELL_W-1:0]    pend_cell_reg, pend_cell_next;
    logic [CNT_OUT_W-1:0] peak_h_reg, peak_h_next;
    logic [CNT_OUT_W-1:0] peak_t_reg, peak_t_next;
    logic [SUM_W-1:0]     step_sum_reg, step_sum_next;
    logic [CELL_W-1:0]    traj_reg, traj_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic [CELL_W-1:0]    hist_mem [DEPTH];
    logic [CELL_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [CELL_W-1:0]    mem_wdata;

    logic [MOD_W-1:0]     mod_nz, eff_mod;
    logic                 req_fire, walk_start;
    logic [CELL_W-1:0]    cell_inc;
    logic [SUM_W:0]       sum_wide;
    walk_stat_t           w_stat;
    logic [CNT_W-1:0]     w_h, w_t;
    logic [MOD_W-1:0]     w_row, w_col;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [MOD_W-1:0] row,
                                                    input logic [MOD_W-1:0] col);
        return ADDR_W'(int'(row) * GRID_SIDE + int'(col));
    endfunction

    // A modulus of zero acts as one; one above the grid side acts as the side.
    assign mod_nz  = (modulus_reg == '0) ? MOD_W'(1) : modulus_reg;
    assign eff_mod = (int'(mod_nz) > GRID_SIDE) ? MOD_W'(GRID_SIDE) : mod_nz;

    assign request.ready = (state_reg == S_IDLE);
    assign setup.ready   = 1'b1;
    assign req_fire      = request.valid && request.ready;
    assign walk_start    = req_fire && (request.cmd == CMD_ACCUM)
                           && (request.start_value != '0);

    cprh_walker #(
        .STEP_LIMIT (STEP_LIMIT),
        .CNT_W      (CNT_W)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (walk_start),
        .start_value (request.start_value),
        .eff_mod     (eff_mod),
        .stat        (w_stat),
        .halvings    (w_h),
        .triplings   (w_t),
        .row         (w_row),
        .col         (w_col)
    );

    always_comb
    begin
        cell_inc = (rd_data_reg == CELL_MAX) ? CELL_MAX : rd_data_reg + CELL_W'(1);
        sum_wide = (SUM_W + 1)'(step_sum_reg) + (SUM_W + 1)'(w_h) + (SUM_W + 1)'(w_t);

        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        addr_next        = addr_reg;
        is_read_next     = is_read_reg;
        pend_status_next = pend_status_reg;
        pend_h_next      = pend_h_reg;
        pend_t_next      = pend_t_reg;
        pend_cell_next   = pend_cell_reg;
        peak_h_next      = peak_h_reg;
        peak_t_next      = peak_t_reg;
        step_sum_next    = step_sum_reg;
        traj_next        = traj_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        mem_wdata        = cell_inc;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    pend_h_next    = '0;
                    pend_t_next    = '0;
                    pend_cell_next = '0;
                    is_read_next   = (request.cmd == CMD_READ);
                    if (request.cmd == CMD_READ)
                    begin
                        if ((MOD_W'(request.read_row) >= eff_mod)
                            || (MOD_W'(request.read_col) >= eff_mod))
                        begin
                            pend_status_next = ST_RANGE;
                            state_next       = S_FINISH;
                        end
                        else
                        begin
                            pend_status_next = ST_OK;
                            addr_next  = cell_addr(MOD_W'(request.read_row),
                                                   MOD_W'(request.read_col));
                            state_next = S_READ;
                        end
                    end
                    else if (request.start_value == '0)
                    begin
                        pend_status_next = ST_ZERO;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (w_stat.done)
                begin
                    pend_h_next      = CNT_OUT_W'(w_h);
                    pend_t_next      = CNT_OUT_W'(w_t);
                    pend_status_next = w_stat.code;
                    if (w_stat.code == ST_OK)
                    begin
                        addr_next  = cell_addr(w_row, w_col);
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_READ:
            begin
                // The memory captures the cell at addr_reg on this edge.
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (is_read_reg)
                begin
                    pend_cell_next = rd_data_reg;
                end
                else
                begin
                    mem_we         = 1'b1;
                    pend_cell_next = cell_inc;
                    if (int'(w_h) > int'(peak_h_reg))
                    begin
                        peak_h_next = (int'(w_h) > int'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                                      : CNT_OUT_W'(w_h);
                    end
                    if (int'(w_t) > int'(peak_t_reg))
                    begin
                        peak_t_next = (int'(w_t) > int'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                                      : CNT_OUT_W'(w_t);
                    end
                    step_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    if (traj_reg != CELL_MAX)
                    begin
                        traj_next = traj_reg + CELL_W'(1);
                    end
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next.status             = pend_status_reg;
                    out_next.halvings           = pend_h_reg;
                    out_next.triplings          = pend_t_reg;
                    out_next.cell_count         = pend_cell_reg;
                    out_next.peak_halvings_out  = peak_h_reg;
                    out_next.peak_triplings_out = peak_t_reg;
                    out_next.steps_total        = step_sum_reg;
                    out_next.trajectories       = traj_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            modulus_reg   <= MOD_W'(3);
            peak_h_reg    <= '0;
            peak_t_reg    <= '0;
            step_sum_reg  <= '0;
            traj_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            peak_h_reg    <= peak_h_next;
            peak_t_reg    <= peak_t_next;
            step_sum_reg  <= step_sum_next;
            traj_reg      <= traj_next;
            out_valid_reg <= out_valid_next;
            if (setup.valid && setup.ready)
            begin
                modulus_reg <= setup.modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        is_read_reg     <= is_read_next;
        pend_status_reg <= pend_status_next;
        pend_h_reg      <= pend_h_next;
        pend_t_reg      <= pend_t_next;
        pend_cell_reg   <= pend_cell_next;
        out_reg         <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= hist_mem[addr_reg];
    end

    assign result.valid              = out_valid_reg;
    assign result.status             = out_reg.status;
    assign result.halvings           = out_reg.halvings;
    assign result.triplings          = out_reg.triplings;
    assign result.cell_count         = out_reg.cell_count;
    assign result.peak_halvings_out  = out_reg.peak_halvings_out;
    assign result.peak_triplings_out = out_reg.peak_triplings_out;
    assign result.steps_total        = out_reg.steps_total;
    assign result.trajectories       = out_reg.trajectories;

endmodule

// ===== design/cprh_walker.sv =====
// Trajectory walker: one shared 64-bit tripling/halving unit stepped once per cycle.
// Keeps the step counts and their running residues. Depends on cprh_pkg.
module cprh_walker
    import cprh_pkg::*;
#(
    parameter int STEP_LIMIT = 4095,
    parameter int CNT_W      = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] start_value,
    input  logic [MOD_W-1:0] eff_mod,
    output walk_stat_t       stat,
    output logic [CNT_W-1:0] halvings,
    output logic [CNT_W-1:0] triplings,
    output logic [MOD_W-1:0] row,
    output logic [MOD_W-1:0] col
);

    logic             active_reg, active_next;
    logic [VAL_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] h_reg, h_next;
    logic [CNT_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [MOD_W-1:0] hres_reg, hres_next;
    logic [MOD_W-1:0] tres_reg, tres_next;
    logic [MOD_W-1:0] hres_inc, tres_inc;
    walk_stat_t       stat_c;

    always_comb
    begin
        hres_inc = hres_reg + MOD_W'(1);
        tres_inc = tres_reg + MOD_W'(1);

        stat_c.done = 1'b0;
        stat_c.code = ST_OK;
        active_next = active_reg;
        cur_next    = cur_reg;
        h_next      = h_reg;
        t_next      = t_reg;
        steps_next  = steps_reg;
        hres_next   = hres_reg;
        tres_next   = tres_reg;

        if (active_reg)
        begin
            if (cur_reg == VAL_W'(1))
            begin
                stat_c.done = 1'b1;
                active_next = 1'b0;
            end
            else if (int'(steps_reg) >= STEP_LIMIT)
            begin
                stat_c.done = 1'b1;
                stat_c.code = ST_LIMIT;
                active_next = 1'b0;
            end
            else if (cur_reg[0] && (cur_reg > TRIPLE_MAX))
            begin
                stat_c.done = 1'b1;
                stat_c.code = ST_OVERFLOW;
                active_next = 1'b0;
            end
            else if (cur_reg[0])
            begin
                cur_next   = {cur_reg[VAL_W-2:0], 1'b0} + cur_reg + VAL_W'(1);
                t_next     = t_reg + CNT_W'(1);
                tres_next  = (tres_inc == eff_mod) ? '0 : tres_inc;
                steps_next = steps_reg + CNT_W'(1);
            end
            else
            begin
                cur_next   = cur_reg >> 1;
                h_next     = h_reg + CNT_W'(1);
                hres_next  = (hres_inc == eff_mod) ? '0 : hres_inc;
                steps_next = steps_reg + CNT_W'(1);
            end
        end

        if (start)
        begin
            active_next = 1'b1;
            cur_next    = start_value;
            h_next      = '0;
            t_next      = '0;
            steps_next  = '0;
            hres_next   = '0;
            tres_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        h_reg     <= h_next;
        t_reg     <= t_next;
        steps_reg <= steps_next;
        hres_reg  <= hres_next;
        tres_reg  <= tres_next;
    end

    assign stat      = stat_c;
    assign halvings  = h_reg;
    assign triplings = t_reg;
    assign row       = hres_reg;
    assign col       = tres_reg;

endmodule
